// ===== src/arp_cache_engine_macros.svh =====
// Assertion macros for the ARP cache engine.
`ifndef ARP_CACHE_ENGINE_MACROS_SVH
`define ARP_CACHE_ENGINE_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define ACE_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define ACE_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ===== src/ace_pkg.sv =====
// Shared types and constants for the ARP cache engine.
package ace_pkg;
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_FRAME  = 2'd2;
   localparam logic [1:0] MODE_UPDATE = 2'd3;

   localparam logic [1:0] KIND_DONE    = 2'd0;
   localparam logic [1:0] KIND_ANSWER  = 2'd1;
   localparam logic [1:0] KIND_REQUEST = 2'd2;
   localparam logic [1:0] KIND_REPLY   = 2'd3;

   localparam logic [1:0] ST_HIT     = 2'd0;
   localparam logic [1:0] ST_PENDING = 2'd1;
   localparam logic [1:0] ST_SENT    = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [15:0] OP_REQUEST = 16'h0001;
   localparam logic [15:0] OP_REPLY   = 16'h0002;

   localparam logic [1:0] REG_OWN_IP  = 2'd0;
   localparam logic [1:0] REG_OWN_MAC = 2'd1;
   localparam logic [1:0] REG_EXPIRE  = 2'd2;
   localparam logic [1:0] REG_RETRIES = 2'd3;

   // classified command from front to back
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_LOOKUP = 3'd1,
      CMD_UPDATE = 3'd2,
      CMD_REPLY  = 3'd3,
      CMD_NOP    = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [7:0]  expire;
   } job_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [47:0] mac;
      logic [31:0] ip;
      logic        last;
   } result_type;
endpackage

// ===== src/ace_front.sv =====
// Front end: accepts input transactions, classifies them and queues jobs.
module ace_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_mode,
   input  logic [31:0]      in_ip,
   input  logic [47:0]      in_mac,
   input  logic [15:0]      in_opcode,
   input  logic [31:0]      in_target,
   input  logic [7:0]       in_expire,
   input  logic [31:0]      own_ip,
   input  logic [7:0]       reply_expire,
   output logic             job_valid,
   input  logic             job_ready,
   output ace_pkg::job_type job
);
   import ace_pkg::*;

   job_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type    cls;
   logic       push, pop;

   always_comb begin
      cls.ip     = in_ip;
      cls.mac    = in_mac;
      cls.expire = in_expire;
      cls.cmd    = CMD_NOP;
      unique case (in_mode)
         MODE_TICK:   cls.cmd = CMD_TICK;
         MODE_LOOKUP: cls.cmd = CMD_LOOKUP;
         MODE_FRAME: begin
            if (in_target == own_ip && in_opcode == OP_REQUEST) cls.cmd = CMD_REPLY;
            else if (in_target == own_ip && in_opcode == OP_REPLY) begin
               cls.cmd    = CMD_UPDATE;
               cls.expire = reply_expire;
            end
         end
         MODE_UPDATE: cls.cmd = CMD_UPDATE;
         default:     cls.cmd = CMD_NOP;
      endcase
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];
   assign push      = in_valid & in_ready;
   assign pop       = job_valid & job_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end
endmodule

// ===== src/ace_back.sv =====
// Back end: walks the table one entry a cycle while the result register can accept, and emits results.
module ace_back #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  ace_pkg::job_type    job,
   input  logic [7:0]          max_retries,
   output logic                res_valid,
   input  logic                res_ready,
   output ace_pkg::result_type res,
   output logic                busy
);
   import ace_pkg::*;
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_FIN  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type   st_ff, st_in;
   job_type     job_ff;
   logic [IW:0] idx_ff, idx_in;
   logic [IW-1:0] ix;
   logic        found_ff, found_in;
   logic [IW-1:0] slot_ff, slot_in, free_ff, free_in;
   logic        hasfree_ff, hasfree_in;
   logic        ov_ff;
   result_type  ob_ff;

   logic [TABLE_ENTRIES-1:0] vld_ff, req_ff;
   logic [7:0]  exp_ff [TABLE_ENTRIES];
   logic [7:0]  rty_ff [TABLE_ENTRIES];
   logic [31:0] eip_ff [TABLE_ENTRIES];
   logic [47:0] emac_ff [TABLE_ENTRIES];

   logic        emit;
   result_type  emit_r;
   logic        can_emit;
   logic [7:0]  rnext;

   assign ix        = idx_ff[IW-1:0];
   assign can_emit  = !ov_ff || res_ready;
   assign res_valid = ov_ff;
   assign res       = ob_ff;
   assign job_ready = (st_ff == S_IDLE);
   assign busy      = (st_ff != S_IDLE) || ov_ff;
   assign rnext     = (rty_ff[ix] == 8'hFF) ? 8'hFF : rty_ff[ix] + 8'd1;

   always_comb begin
      st_in      = st_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      slot_in    = slot_ff;
      free_in    = free_ff;
      hasfree_in = hasfree_ff;
      emit       = 1'b0;
      emit_r     = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (job_valid) begin
               idx_in     = '0;
               found_in   = 1'b0;
               hasfree_in = 1'b0;
               st_in      = (job.cmd == CMD_REPLY || job.cmd == CMD_NOP) ? S_FIN : S_WALK;
            end
         end
         S_WALK: begin
            if (can_emit) begin
               if (job_ff.cmd == CMD_TICK) begin
                  if (req_ff[ix] && rnext < max_retries) begin
                     emit        = 1'b1;
                     emit_r.kind = KIND_REQUEST;
                     emit_r.ip   = eip_ff[ix];
                  end
               end else if (!found_in) begin
                  if (job_ff.cmd == CMD_LOOKUP) begin
                     if ((vld_ff[ix] || req_ff[ix]) && eip_ff[ix] == job_ff.ip) begin
                        found_in = 1'b1;
                        slot_in  = ix;
                     end else if (!vld_ff[ix] && !req_ff[ix] && !hasfree_ff) begin
                        hasfree_in = 1'b1;
                        free_in    = ix;
                     end
                  end else begin
                     if (eip_ff[ix] == job_ff.ip) begin
                        found_in = 1'b1;
                        slot_in  = ix;
                     end else if (!vld_ff[ix] && !req_ff[ix] && !hasfree_ff) begin
                        hasfree_in = 1'b1;
                        free_in    = ix;
                     end
                  end
               end
               idx_in = idx_ff + 1'b1;
               if (found_in || idx_ff == (IW+1)'(TABLE_ENTRIES - 1)) st_in = S_FIN;
            end
         end
         S_FIN: begin
            if (can_emit) begin
               emit     = 1'b1;
               emit_r.last = 1'b1;
               st_in    = S_IDLE;
               case (job_ff.cmd)
                  CMD_REPLY: begin
                     emit_r.kind = KIND_REPLY;
                     emit_r.mac  = job_ff.mac;
                     emit_r.ip   = job_ff.ip;
                  end
                  CMD_LOOKUP: begin
                     emit_r.kind = KIND_ANSWER;
                     if (found_ff) begin
                        emit_r.status = vld_ff[slot_ff] ? ST_HIT : ST_PENDING;
                        emit_r.mac    = vld_ff[slot_ff] ? emac_ff[slot_ff] : 48'd0;
                     end else if (hasfree_ff) begin
                        // request first, answer next
                        emit_r.kind = KIND_REQUEST;
                        emit_r.ip   = job_ff.ip;
                        emit_r.last = 1'b0;
                        st_in       = S_EMIT;
                     end else begin
                        emit_r.status = ST_FULL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EMIT: begin
            if (can_emit) begin
               emit          = 1'b1;
               emit_r.kind   = KIND_ANSWER;
               emit_r.status = ST_SENT;
               emit_r.last   = 1'b1;
               st_in         = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         ov_ff  <= 1'b0;
         vld_ff <= '0;
         req_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            exp_ff[i]  <= 8'd0;
            rty_ff[i]  <= 8'd0;
            eip_ff[i]  <= 32'd0;
            emac_ff[i] <= 48'd0;
         end
      end else begin
         st_ff <= st_in;
         if (emit) ov_ff <= 1'b1;
         else if (res_ready) ov_ff <= 1'b0;
         if (st_ff == S_WALK && can_emit && job_ff.cmd == CMD_TICK) begin
            if (vld_ff[ix]) begin
               if (exp_ff[ix] != 8'd0) exp_ff[ix] <= exp_ff[ix] - 8'd1;
               else vld_ff[ix] <= 1'b0;
            end
            if (req_ff[ix]) begin
               rty_ff[ix] <= rnext;
               if (!(rnext < max_retries)) req_ff[ix] <= 1'b0;
            end
         end
         if (st_ff == S_FIN && can_emit && job_ff.cmd == CMD_LOOKUP && !found_ff
             && hasfree_ff) begin
            eip_ff[free_ff] <= job_ff.ip;
            rty_ff[free_ff] <= 8'd0;
            vld_ff[free_ff] <= 1'b0;
            req_ff[free_ff] <= 1'b1;
         end
         if (st_ff == S_FIN && can_emit && job_ff.cmd == CMD_UPDATE
             && (found_ff || hasfree_ff)) begin
            vld_ff[found_ff ? slot_ff : free_ff]  <= 1'b1;
            req_ff[found_ff ? slot_ff : free_ff]  <= 1'b0;
            eip_ff[found_ff ? slot_ff : free_ff]  <= job_ff.ip;
            emac_ff[found_ff ? slot_ff : free_ff] <= job_ff.mac;
            if (exp_ff[found_ff ? slot_ff : free_ff] < job_ff.expire)
               exp_ff[found_ff ? slot_ff : free_ff] <= job_ff.expire;
         end
      end
      if (st_ff == S_IDLE && job_valid) job_ff <= job;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      free_ff    <= free_in;
      hasfree_ff <= hasfree_in;
      if (emit) ob_ff <= emit_r;
   end
endmodule

// ===== src/arp_cache_engine.sv =====
// Top level of the ARP cache engine: CSR block, front end and back end.
// Frames that need no table search pass from the job queue through idle and finish to the
// registered result; lookups, updates and reply frames walk up to TABLE_ENTRIES entries one a
// cycle while the output does not stall, ticks walk all. The back end works a job through idle,
// a step per entry walked, finish, and the answer after a fresh request, then takes the next.
// A two-deep job queue lets the front accept while the back walks.
// Reset is synchronous: table cleared, registers back to their defaults.
module arp_cache_engine #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: mode[1:0], ip_addr[33:2], mac_addr[81:34], opcode[97:82],
   //        target_ip[129:98], expire_value[137:130], zero pad to 144
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: kind[1:0], status[3:2], mac_out[51:4], ip_out[83:52], pad to 88
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import ace_pkg::*;
   `include "arp_cache_engine_macros.svh"

   logic [31:0] own_ip_ff;
   logic [47:0] own_mac_ff;
   logic [7:0]  reply_expire_ff, max_retries_ff;
   logic        wr;
   logic [1:0]  ridx;
   logic        job_valid, job_ready, busy;
   job_type     job;
   result_type  res;

   // registers lie at 8*i since own_mac is wider than 32 bits
   assign csr_pready = 1'b1;
   assign ridx       = csr_paddr[4:3];
   assign wr         = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2:0] == 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff       <= 32'd0;
         own_mac_ff      <= 48'd0;
         reply_expire_ff <= 8'd60;
         max_retries_ff  <= 8'd4;
      end else if (wr) begin
         unique case (ridx)
            REG_OWN_IP:  own_ip_ff       <= csr_pwdata[31:0];
            REG_OWN_MAC: own_mac_ff      <= csr_pwdata[47:0];
            REG_EXPIRE:  reply_expire_ff <= csr_pwdata[7:0];
            REG_RETRIES: max_retries_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      csr_prdata = 64'd0;
      if (csr_paddr[2:0] == 3'd0) begin
         unique case (ridx)
            REG_OWN_IP:  csr_prdata = {32'd0, own_ip_ff};
            REG_OWN_MAC: csr_prdata = {16'd0, own_mac_ff};
            REG_EXPIRE:  csr_prdata = {56'd0, reply_expire_ff};
            REG_RETRIES: csr_prdata = {56'd0, max_retries_ff};
            default:     csr_prdata = 64'd0;
         endcase
      end
   end

   ace_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_mode(req_tdata[1:0]), .in_ip(req_tdata[33:2]), .in_mac(req_tdata[81:34]),
      .in_opcode(req_tdata[97:82]), .in_target(req_tdata[129:98]),
      .in_expire(req_tdata[137:130]),
      .own_ip(own_ip_ff), .reply_expire(reply_expire_ff),
      .job_valid, .job_ready, .job
   );

   ace_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .max_retries(max_retries_ff),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res, .busy
   );

   assign rsp_tdata = {4'd0, res.ip, res.mac, res.status, res.kind};
   assign rsp_tlast = res.last;

   // assertions
   `ACE_ASSERT_IMP(a_busy_out, clock, reset, rsp_tvalid, busy)
   `ACE_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ACE_ASSERT_IMP(a_status, clock, reset, rsp_tvalid && res.kind != KIND_ANSWER,
                   res.status == ST_HIT)
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the ARP cache engine: directed table, then randomised phases.
`timescale 1ns / 100ps

module tb;
   import ace_pkg::*;

   localparam int NUM_ENTRIES = 16;
   localparam int STALL_MAX   = 16;
   localparam int IDLE_LIMIT  = 5000;
   localparam int TAIL_CYCLES = 60;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;  // mode, ip_addr, mac_addr, opcode, target_ip, expire_value
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [87:0]   rsp_tdata;       // kind, status, mac_out, ip_out
   logic          rsp_tlast;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [4:0]    csr_paddr = '0;
   logic [63:0]   csr_pwdata = '0;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   arp_cache_engine #(.TABLE_ENTRIES(NUM_ENTRIES)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] opcode;
      logic [31:0] tip;
      logic [7:0]  expire;
   } arp_event_type;

   // Directed row: event plus, where obvious, the kind/status of its final result
   typedef struct {
      arp_event_type ev;
      bit            known;
      logic [1:0]    kind;
      logic [1:0]    status;
   } directed_row_type;

   // Shadow copy of the cache and its registers
   logic [31:0] sh_own_ip;
   logic [47:0] sh_own_mac;
   logic [7:0]  sh_reply_expire;
   logic [7:0]  sh_max_retries;
   bit          sh_valid  [NUM_ENTRIES];
   bit          sh_pending[NUM_ENTRIES];
   logic [7:0]  sh_expire [NUM_ENTRIES];
   logic [7:0]  sh_retry  [NUM_ENTRIES];
   logic [31:0] sh_ip     [NUM_ENTRIES];
   logic [47:0] sh_mac    [NUM_ENTRIES];

   result_type  pending_results[$];
   int          fail_count;
   int          idle_cycles;
   int          kind_seen[4];
   int          events_sent;
   bit          calm;           // when set, neither side idles
   int          rx_hold;
   logic [31:0] ip_pool[8];

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold reset from time zero and release it once only
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void push_result(logic [1:0] kind, logic [1:0] status,
                                       logic [47:0] mac, logic [31:0] ip, logic last);
      result_type r;
      r.kind = kind; r.status = status; r.mac = mac; r.ip = ip; r.last = last;
      pending_results.push_back(r);
   endfunction

   // Learn a mapping: reuse the entry holding this IP, else the first free entry
   function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac, logic [7:0] exp);
      int slot = -1;
      int free_slot = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (sh_ip[i] == ip) begin
            slot = i;
            break;
         end
         if (!sh_valid[i] && !sh_pending[i] && free_slot < 0) free_slot = i;
      end
      if (slot < 0) slot = free_slot;
      if (slot < 0) return;   // table full: drop the mapping
      sh_valid[slot]   = 1'b1;
      sh_pending[slot] = 1'b0;
      if (sh_expire[slot] < exp) sh_expire[slot] = exp;
      sh_ip[slot]  = ip;
      sh_mac[slot] = mac;
   endfunction

   // Work out the results one event causes and queue them
   function automatic void predict_arp_results(arp_event_type ev);
      int free_slot = -1;
      bit used;
      case (ev.mode)
         MODE_TICK: begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (sh_valid[i]) begin
                  if (sh_expire[i] != 0) sh_expire[i]--;
                  else sh_valid[i] = 1'b0;
               end
               if (sh_pending[i]) begin
                  if (sh_retry[i] != 8'hFF) sh_retry[i]++;
                  if (sh_retry[i] < sh_max_retries) push_result(KIND_REQUEST, 0, 0, sh_ip[i], 0);
                  else sh_pending[i] = 1'b0;
               end
            end
            push_result(KIND_DONE, 0, 0, 0, 1);
         end
         MODE_LOOKUP: begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               used = sh_valid[i] || sh_pending[i];
               if (used && sh_ip[i] == ev.ip) begin
                  if (sh_valid[i]) push_result(KIND_ANSWER, ST_HIT, sh_mac[i], 0, 1);
                  else push_result(KIND_ANSWER, ST_PENDING, 0, 0, 1);
                  return;
               end
               if (!used && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
               push_result(KIND_ANSWER, ST_FULL, 0, 0, 1);
               return;
            end
            sh_ip[free_slot]      = ev.ip;
            sh_retry[free_slot]   = 0;
            sh_valid[free_slot]   = 1'b0;
            sh_pending[free_slot] = 1'b1;
            push_result(KIND_REQUEST, 0, 0, ev.ip, 0);
            push_result(KIND_ANSWER, ST_SENT, 0, 0, 1);
         end
         MODE_FRAME: begin
            if (ev.tip == sh_own_ip && ev.opcode == OP_REQUEST) begin
               push_result(KIND_REPLY, 0, ev.mac, ev.ip, 1);
               return;
            end
            if (ev.tip == sh_own_ip && ev.opcode == OP_REPLY)
               learn_mapping(ev.ip, ev.mac, sh_reply_expire);
            push_result(KIND_DONE, 0, 0, 0, 1);
         end
         default: begin
            learn_mapping(ev.ip, ev.mac, ev.expire);
            push_result(KIND_DONE, 0, 0, 0, 1);
         end
      endcase
   endfunction

   // Present one event after an optional gap; predict on acceptance.
   // Valid stays high between back-to-back transactions.
   task automatic send_event(arp_event_type ev, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, ev.expire, ev.tip, ev.opcode, ev.mac, ev.ip, ev.mode};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_arp_results(ev);
      events_sent++;
   endtask

   // Drop valid and hold until every expected transaction has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);   // register takes the value at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_OWN_IP:  sh_own_ip       = value[31:0];
         REG_OWN_MAC: sh_own_mac      = value[47:0];
         REG_EXPIRE:  sh_reply_expire = value[7:0];
         default:     sh_max_retries  = value[7:0];
      endcase
   endtask

   function automatic logic [47:0] random_mac();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, STALL_MAX);
   endfunction

   // Mostly well-formed traffic around a small pool of addresses, plus noise
   function automatic arp_event_type random_event();
      arp_event_type ev;
      int pick = $urandom_range(0, 99);
      ev.ip     = ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
      ev.mac    = random_mac();
      ev.opcode = $urandom_range(0, 1) ? OP_REPLY : OP_REQUEST;
      ev.tip    = sh_own_ip;
      ev.expire = 8'($urandom());
      if (pick < 20)      ev.mode = MODE_TICK;
      else if (pick < 50) ev.mode = MODE_LOOKUP;
      else if (pick < 85) ev.mode = MODE_FRAME;
      else                ev.mode = MODE_UPDATE;
      if (ev.mode == MODE_FRAME && $urandom_range(0, 7) == 0) ev.opcode = 16'($urandom());
      if (ev.mode == MODE_FRAME && $urandom_range(0, 7) == 0) ev.tip = $urandom();
      return ev;
   endfunction

   function automatic arp_event_type mk(logic [1:0] mode, logic [31:0] ip, logic [47:0] mac,
                                        logic [15:0] opcode, logic [31:0] tip,
                                        logic [7:0] expire);
      arp_event_type ev;
      ev.mode = mode; ev.ip = ip; ev.mac = mac; ev.opcode = opcode; ev.tip = tip;
      ev.expire = expire;
      return ev;
   endfunction

   // Result side: check every transaction, then hold ready low for a random gap (none when calm)
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold    = 1;
      end else if (rsp_tvalid && rsp_tready) begin
         seen.kind = rsp_tdata[1:0];
         seen.status = rsp_tdata[3:2];
         seen.mac = rsp_tdata[51:4];
         seen.ip = rsp_tdata[83:52];
         seen.last = rsp_tlast;
         kind_seen[seen.kind]++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d status %0d", seen.kind, seen.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (seen.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, seen.kind); fail_count++;
            end
            if (seen.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, seen.status);
               fail_count++;
            end
            if (seen.mac !== want.mac) begin
               $error("mac_out: expected %h, actual %h", want.mac, seen.mac); fail_count++;
            end
            if (seen.ip !== want.ip) begin
               $error("ip_out: expected %h, actual %h", want.ip, seen.ip); fail_count++;
            end
            if (seen.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, seen.last); fail_count++;
            end
         end
         rx_hold = draw_gap();
         rsp_tready <= (rx_hold == 0);
      end else if (rx_hold > 0) begin
         rx_hold--;
         if (rx_hold == 0) rsp_tready <= 1'b1;
      end
   end

   // Watchdog: count cycles with no transaction on either stream
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: %0d results still outstanding", pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      directed_row_type rows[$];
      arp_event_type    ev;
      logic [31:0]      phase_ip;
      sh_own_ip = 0; sh_own_mac = 0; sh_reply_expire = 8'd60; sh_max_retries = 8'd4;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         sh_valid[i] = 0; sh_pending[i] = 0; sh_expire[i] = 0; sh_retry[i] = 0;
         sh_ip[i] = 0; sh_mac[i] = 0;
      end
      fail_count = 0; idle_cycles = 0; events_sent = 0; calm = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;

      // hold off until reset has been released
      wait (reset == 1'b0);
      @(posedge clock);

      // Directed table, run with registers at their reset values (own_ip zero)
      rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0), 1, KIND_DONE, 0});
      rows.push_back('{mk(MODE_LOOKUP, 32'h0A000001, 0, 0, 0, 0), 1, KIND_ANSWER, ST_SENT});
      rows.push_back('{mk(MODE_LOOKUP, 32'h0A000001, 0, 0, 0, 0), 1, KIND_ANSWER, ST_PENDING});
      rows.push_back('{mk(MODE_FRAME, 32'h0A000001, 48'hFFFFFFFFFFFF, OP_REPLY, 0, 0),
                       1, KIND_DONE, 0});
      rows.push_back('{mk(MODE_LOOKUP, 32'h0A000001, 0, 0, 0, 0), 1, KIND_ANSWER, ST_HIT});
      rows.push_back('{mk(MODE_FRAME, 32'hFFFFFFFF, 0, OP_REQUEST, 0, 0), 1, KIND_REPLY, 0});
      // frame for another host, and an unknown opcode: both ignored
      rows.push_back('{mk(MODE_FRAME, 32'h01020304, 48'h1, OP_REQUEST, 32'hFFFFFFFF, 0),
                       1, KIND_DONE, 0});
      rows.push_back('{mk(MODE_FRAME, 32'h01020304, 48'h1, 16'hFFFF, 0, 8'hFF), 1, KIND_DONE, 0});
      // update hitting the stale zero IP of a free entry, then a smaller expiry
      rows.push_back('{mk(MODE_UPDATE, 0, 48'h123456789ABC, 0, 0, 8'hFF), 1, KIND_DONE, 0});
      rows.push_back('{mk(MODE_UPDATE, 0, 48'hA5A5A5A5A5A5, 16'hFFFF, 32'hFFFFFFFF, 0),
                       1, KIND_DONE, 0});
      rows.push_back('{mk(MODE_LOOKUP, 0, 0, 0, 0, 0), 0, 0, 0});
      rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0), 1, KIND_DONE, 0});
      foreach (rows[r]) begin
         send_event(rows[r].ev, $urandom_range(0, 3));
         if (rows[r].known && (pending_results[$].kind !== rows[r].kind ||
                               pending_results[$].status !== rows[r].status)) begin
            $error("directed row %0d: kind/status expected %0d/%0d, predicted %0d/%0d", r,
                   rows[r].kind, rows[r].status, pending_results[$].kind,
                   pending_results[$].status);
            fail_count++;
         end
      end
      // Fill the rest of the table with requests, overflow it, then tick every retry
      for (int k = 0; k < NUM_ENTRIES - 2; k++)
         send_event(mk(MODE_LOOKUP, 32'h0B000000 + k, 0, 0, 0, 0), 0);
      send_event(mk(MODE_LOOKUP, 32'h0C000000, 0, 0, 0, 0), 1);       // table full
      send_event(mk(MODE_UPDATE, 32'h0D000000, 48'h5, 0, 0, 8'd9), 0); // dropped
      repeat (5) send_event(mk(MODE_TICK, 0, 0, 0, 0, 0), $urandom_range(0, 2));
      drain();

      // Random phases, each with its own register setting; extremes included
      for (int phase = 0; phase < 4; phase++) begin
         phase_ip = $urandom();
         csr_write(REG_OWN_IP, 64'((phase == 3) ? 32'hFFFFFFFF : phase_ip));
         csr_write(REG_OWN_MAC, 64'((phase == 0) ? 48'hFFFFFFFFFFFF : random_mac()));
         csr_write(REG_EXPIRE, 64'((phase == 1) ? 8'd0 : (phase == 2) ? 8'd255 :
                                   8'($urandom_range(1, 9))));
         csr_write(REG_RETRIES, 64'((phase == 1) ? 8'd1 : (phase == 2) ? 8'd255 :
                                    8'($urandom_range(2, 6))));
         foreach (ip_pool[p]) ip_pool[p] = (p == 0) ? 32'd0 : $urandom();
         calm = (phase == 2);
         for (int n = 0; n < 30; n++) begin
            ev = random_event();
            send_event(ev, draw_gap());
         end
         drain();
      end

      calm = 1;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d events across 5 register settings", events_sent);
      $display("results: %0d done, %0d answers, %0d requests, %0d replies",
               kind_seen[KIND_DONE], kind_seen[KIND_ANSWER], kind_seen[KIND_REQUEST],
               kind_seen[KIND_REPLY]);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+src
src/ace_pkg.sv
src/ace_front.sv
src/ace_back.sv
src/arp_cache_engine.sv
verif/tb.sv
